// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the cursor overlay RTL.
// No dependencies; included by every module that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

// ----- hw/rtl/csao_pkg.sv -----
// Types and constants for the cursor sprite alpha overlay.
// No dependencies; used by the top level, the front end and the back end.
package csao_pkg;

   localparam int FRAME_MAX_SIDE = 4096;
   localparam int MID_DEPTH      = 8;
   localparam int OUT_DEPTH      = 4;

   localparam logic [7:0] FULL_ALPHA = 8'd255;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_BLEND = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_LEFT   = 2'd2,
      CSR_TOP    = 2'd3
   } csr_index_type;

   typedef struct packed {
      mode_type    mode;
      logic [11:0] sprite_index;
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [7:0]  alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic [7:0] out_alpha;
      logic       covered;
   } rsp_type;

   typedef struct packed {
      logic [6:0]         sprite_width;
      logic [6:0]         sprite_height;
      logic signed [12:0] sprite_left;
      logic signed [12:0] sprite_top;
   } cfg_type;

   // B in the low byte, A in the high byte
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } texel_type;

   typedef struct packed {
      logic      hit;
      texel_type texel;
      texel_type pixel;
   } mid_type;

endpackage

// ----- hw/rtl/cursor_sprite_alpha_overlay.sv -----
// Top level of the hardware cursor overlay: config registers, front end,
// decoupling queues and blend back end. Depends on csao_pkg and submodules.
//
//   channel   handshake          payload
//   request   push / full        req_item  (csao_pkg::req_type)
//   response  pop / empty        rsp_item  (csao_pkg::rsp_type)
//   config    valid / ready      csr_index, csr_data
//
// One item per clock sustained while full is low; a blend result passes in
// order through the coverage test, texel address, sprite store read, the
// middle queue, the blend multiply and the result queue. Loads give no result.
// Synchronous reset clears all control state and sets the sprite to 32x32
// at the origin; the sprite store is not cleared. A stalled response side
// backs up through the queues to full.
module cursor_sprite_alpha_overlay #(
   parameter int SPRITE_MAX_SIDE = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  csao_pkg::req_type       req_item,
   input  logic                    pop,
   output logic                    empty,
   output csao_pkg::rsp_type       rsp_item,
   input  logic                    valid,
   output logic                    ready,
   input  csao_pkg::csr_index_type csr_index,
   input  logic [12:0]             csr_data
);

   localparam int MID_W     = $bits(csao_pkg::mid_type);
   localparam int RSP_W     = $bits(csao_pkg::rsp_type);
   localparam int MID_CNT_W = $clog2(csao_pkg::MID_DEPTH + 1);
   localparam int OUT_CNT_W = $clog2(csao_pkg::OUT_DEPTH + 1);

   csao_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (valid) begin
         case (csr_index)
            csao_pkg::CSR_WIDTH:  cfg_in.sprite_width  = csr_data[6:0];
            csao_pkg::CSR_HEIGHT: cfg_in.sprite_height = csr_data[6:0];
            csao_pkg::CSR_LEFT:   cfg_in.sprite_left   = $signed(csr_data);
            csao_pkg::CSR_TOP:    cfg_in.sprite_top    = $signed(csr_data);
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{sprite_width: 7'd32, sprite_height: 7'd32,
                     sprite_left: 13'sd0, sprite_top: 13'sd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign ready = 1'b1;

   logic                  accept;
   logic                  mid_push, mid_pop, mid_empty;
   csao_pkg::mid_type     mid_wr_item, mid_rd_item;
   logic [MID_W-1:0]      mid_rd_bits;
   logic [MID_CNT_W-1:0]  mid_count;
   logic                  out_push, out_pop;
   csao_pkg::rsp_type     out_wr_item;
   logic [RSP_W-1:0]      out_rd_bits;
   logic [OUT_CNT_W-1:0]  out_count;

   assign accept = push && !full;

   csao_front #(
      .SPRITE_MAX_SIDE(SPRITE_MAX_SIDE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_item  (req_item),
      .cfg       (cfg_ff),
      .mid_count (mid_count),
      .full      (full),
      .mid_push  (mid_push),
      .mid_item  (mid_wr_item)
   );

   csao_fifo #(
      .DEPTH(csao_pkg::MID_DEPTH),
      .WIDTH(MID_W)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mid_push),
      .wr_data (MID_W'(mid_wr_item)),
      .rd_en   (mid_pop),
      .rd_data (mid_rd_bits),
      .count   (mid_count),
      .empty   (mid_empty)
   );

   assign mid_rd_item = csao_pkg::mid_type'(mid_rd_bits);

   csao_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_item  (mid_rd_item),
      .mid_empty (mid_empty),
      .out_count (out_count),
      .mid_pop   (mid_pop),
      .out_push  (out_push),
      .out_item  (out_wr_item)
   );

   assign out_pop = pop && !empty;

   csao_fifo #(
      .DEPTH(csao_pkg::OUT_DEPTH),
      .WIDTH(RSP_W)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (RSP_W'(out_wr_item)),
      .rd_en   (out_pop),
      .rd_data (out_rd_bits),
      .count   (out_count),
      .empty   (empty)
   );

   assign rsp_item = csao_pkg::rsp_type'(out_rd_bits);

endmodule

// ----- hw/rtl/csao_fifo.sv -----
// Small synchronous queue with a combinational head, used between stages.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module csao_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [WIDTH-1:0]             wr_data,
   input  logic                         rd_en,
   output logic [WIDTH-1:0]             rd_data,
   output logic [$clog2(DEPTH+1)-1:0]   count,
   output logic                         empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem[rd_ptr_ff];
   assign count   = count_ff;
   assign empty   = (count_ff == '0);

   `ASSERT_IMPLIES(a_fifo_no_overflow, clock, reset, wr_en && !rd_en, count_ff != CNT_W'(DEPTH), "queue overflow")
   `ASSERT_IMPLIES(a_fifo_no_underflow, clock, reset, rd_en, count_ff != '0, "queue underflow")

endmodule

// ----- hw/rtl/csao_front.sv -----
// Front end: takes items, tests sprite coverage, forms the texel address
// and owns the sprite store. Depends on csao_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csao_front #(
   parameter int SPRITE_MAX_SIDE = 64
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       accept,
   input  csao_pkg::req_type                          req_item,
   input  csao_pkg::cfg_type                          cfg,
   input  logic [$clog2(csao_pkg::MID_DEPTH+1)-1:0]   mid_count,
   output logic                                       full,
   output logic                                       mid_push,
   output csao_pkg::mid_type                          mid_item
);

   localparam int DEPTH = SPRITE_MAX_SIDE * SPRITE_MAX_SIDE;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int SUM_W = (IDX_W > 15) ? IDX_W : 15;
   localparam int CNT_W = $clog2(csao_pkg::MID_DEPTH + 1);
   localparam logic [14:0] FRAME_LIM = 15'(csao_pkg::FRAME_MAX_SIDE);

   // stage 1: coverage test
   logic signed [13:0] dx_c, dy_c;
   logic               in_x_c, in_y_c, hit_c;

   logic               s1_valid_ff;
   csao_pkg::req_type  s1_item_ff;
   logic               s1_hit_ff;
   logic [6:0]         s1_dx_ff, s1_dy_ff;

   always_comb begin
      dx_c   = $signed({2'b00, req_item.pixel_x})
             - $signed({cfg.sprite_left[12], cfg.sprite_left});
      dy_c   = $signed({2'b00, req_item.pixel_y})
             - $signed({cfg.sprite_top[12], cfg.sprite_top});
      in_x_c = ({3'b000, req_item.pixel_x} < FRAME_LIM);
      in_y_c = ({3'b000, req_item.pixel_y} < FRAME_LIM);
      hit_c  = in_x_c && in_y_c && !dx_c[13] && !dy_c[13]
             && (dx_c[12:0] < {6'b000000, cfg.sprite_width})
             && (dy_c[12:0] < {6'b000000, cfg.sprite_height});
   end

   // stage 2: texel address
   logic [SUM_W-1:0]    sum_c, load_c;
   logic [IDX_W-1:0]    addr_c;

   logic                s2_valid_ff;
   logic                s2_load_ff;
   logic                s2_hit_ff;
   logic [IDX_W-1:0]    s2_addr_ff;
   csao_pkg::texel_type s2_pixel_ff;

   always_comb begin
      sum_c  = SUM_W'(s1_dy_ff) * SUM_W'(cfg.sprite_width) + SUM_W'(s1_dx_ff);
      load_c = SUM_W'(s1_item_ff.sprite_index);
      addr_c = (s1_item_ff.mode == csao_pkg::MODE_LOAD) ? load_c[IDX_W-1:0]
                                                        : sum_c[IDX_W-1:0];
   end

   // stage 3: sprite store access
   csao_pkg::texel_type mem [DEPTH];
   csao_pkg::texel_type rdata_ff;
   logic                s3_valid_ff;
   logic                s3_hit_ff;
   csao_pkg::texel_type s3_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff && !s2_load_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= req_item;
      s1_hit_ff   <= hit_c;
      s1_dx_ff    <= dx_c[6:0];
      s1_dy_ff    <= dy_c[6:0];
      s2_load_ff  <= (s1_item_ff.mode == csao_pkg::MODE_LOAD);
      s2_hit_ff   <= s1_hit_ff;
      s2_addr_ff  <= addr_c;
      s2_pixel_ff <= '{alpha: s1_item_ff.alpha, red: s1_item_ff.red,
                       green: s1_item_ff.green, blue: s1_item_ff.blue};
      s3_hit_ff   <= s2_hit_ff;
      s3_pixel_ff <= s2_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_load_ff) begin
         mem[s2_addr_ff] <= s2_pixel_ff;
      end
      rdata_ff <= mem[s2_addr_ff];
   end

   // room is reserved in the queue for every item still in the pipe
   logic [1:0]       inflight;
   logic [CNT_W:0]   claimed;

   always_comb begin
      inflight = 2'(s1_valid_ff) + 2'(s2_valid_ff) + 2'(s3_valid_ff);
      claimed  = {1'b0, mid_count} + (CNT_W + 1)'(inflight);
      full     = (claimed >= (CNT_W + 1)'(csao_pkg::MID_DEPTH));
   end

   assign mid_push = s3_valid_ff;
   assign mid_item = '{hit: s3_hit_ff, texel: rdata_ff, pixel: s3_pixel_ff};

   `ASSERT_ALWAYS(a_front_credit, clock, reset, claimed <= (CNT_W + 1)'(csao_pkg::MID_DEPTH), "queue over-committed")
   `ASSERT_IMPLIES(a_front_hit_range, clock, reset, s1_valid_ff && s1_hit_ff, s1_dx_ff < cfg.sprite_width, "hit outside sprite width")

endmodule

// ----- hw/rtl/csao_back.sv -----
// Back end: blends the texel over covered frame pixels, passes uncovered ones
// through and hands the result on. Depends on csao_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csao_back (
   input  logic                                       clock,
   input  logic                                       reset,
   input  csao_pkg::mid_type                          mid_item,
   input  logic                                       mid_empty,
   input  logic [$clog2(csao_pkg::OUT_DEPTH+1)-1:0]   out_count,
   output logic                                       mid_pop,
   output logic                                       out_push,
   output csao_pkg::rsp_type                          out_item
);

   localparam int CNT_W = $clog2(csao_pkg::OUT_DEPTH + 1);

   // floor(x / 255) for x up to 255*255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'(x[15:8]) + 17'd1;
      return t[15:8];
   endfunction

   logic [7:0]  src_c [3];
   logic [7:0]  dst_c [3];
   logic [7:0]  inv_c;
   logic [15:0] sum_c [3];

   logic                b1_valid_ff;
   logic                b1_hit_ff;
   csao_pkg::texel_type b1_pixel_ff;
   logic [15:0]         b1_sum_ff [3];

   always_comb begin
      mid_pop = !mid_empty
              && (({1'b0, out_count} + (CNT_W + 1)'(b1_valid_ff))
                  < (CNT_W + 1)'(csao_pkg::OUT_DEPTH));
      src_c[0] = mid_item.texel.blue;
      src_c[1] = mid_item.texel.green;
      src_c[2] = mid_item.texel.red;
      dst_c[0] = mid_item.pixel.blue;
      dst_c[1] = mid_item.pixel.green;
      dst_c[2] = mid_item.pixel.red;
      inv_c    = csao_pkg::FULL_ALPHA - mid_item.texel.alpha;
      for (int i = 0; i < 3; i++) begin
         sum_c[i] = 16'(16'(src_c[i]) * 16'(mid_item.texel.alpha))
                  + 16'(16'(dst_c[i]) * 16'(inv_c));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= mid_pop;
      end
   end

   always_ff @(posedge clock) begin
      b1_hit_ff   <= mid_item.hit;
      b1_pixel_ff <= mid_item.pixel;
      for (int i = 0; i < 3; i++) begin
         b1_sum_ff[i] <= sum_c[i];
      end
   end

   always_comb begin
      out_push = b1_valid_ff;
      if (b1_hit_ff) begin
         out_item = '{out_blue:  div255(b1_sum_ff[0]),
                      out_green: div255(b1_sum_ff[1]),
                      out_red:   div255(b1_sum_ff[2]),
                      out_alpha: csao_pkg::FULL_ALPHA,
                      covered:   1'b1};
      end else begin
         out_item = '{out_blue:  b1_pixel_ff.blue,
                      out_green: b1_pixel_ff.green,
                      out_red:   b1_pixel_ff.red,
                      out_alpha: b1_pixel_ff.alpha,
                      covered:   1'b0};
      end
   end

   `ASSERT_IMPLIES(a_back_room, clock, reset, out_push, out_count != CNT_W'(csao_pkg::OUT_DEPTH), "result queue over-committed")

endmodule
